### hdl/keypoint_object_environment_split_macros.svh
// assertion macros shared by the checker of the keypoint splitter
`ifndef KEYPOINT_OBJECT_ENVIRONMENT_SPLIT_MACROS_SVH
`define KEYPOINT_OBJECT_ENVIRONMENT_SPLIT_MACROS_SVH

// property checked on every clock edge outside reset
`define KOES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define KOES_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/koes_pkg.sv
// shared types and constants of the keypoint object/environment splitter
`default_nettype none

package koes_pkg;

    localparam int MAX_POINTS_DEF = 1024;

    localparam int KIND_W  = 2;
    localparam int COORD_W = 16;
    localparam int INDEX_W = 16;
    localparam int DEPTH_W = 16;
    localparam int MASK_W  = 8;
    localparam int SIL_W   = 12;
    localparam int CAT_W   = 2;
    localparam int DIM_W   = 13;
    localparam int DIST_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ENTRY_W    = 2 * SIL_W;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd2;

    // result categories
    localparam logic [CAT_W-1:0] CAT_OUTSIDE = 2'd0;
    localparam logic [CAT_W-1:0] CAT_REJECT  = 2'd1;
    localparam logic [CAT_W-1:0] CAT_OBJECT  = 2'd2;
    localparam logic [CAT_W-1:0] CAT_ENV     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_PRESENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MASK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OBJ_DIST     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_DIST     = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } koes_state_t;

    // controller to datapath
    typedef struct packed {
        logic take_clear;
        logic take_load;
        logic take_class;
        logic scan_rd;
        logic publish;
    } koes_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_needed;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } koes_stat_t;

endpackage

`default_nettype wire

### hdl/koes_in_if.sv
// input item channel
`default_nettype none

interface koes_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [koes_pkg::KIND_W-1:0]           kind;
    logic signed [koes_pkg::COORD_W-1:0]   key_u;
    logic signed [koes_pkg::COORD_W-1:0]   key_v;
    logic [koes_pkg::INDEX_W-1:0]          key_index;
    logic [koes_pkg::DEPTH_W-1:0]          depth_sample;
    logic [koes_pkg::MASK_W-1:0]           mask_sample;
    logic [koes_pkg::SIL_W-1:0]            sil_row;
    logic [koes_pkg::SIL_W-1:0]            sil_col;
    logic                                  sil_flag;

    modport source (
        output valid, kind, key_u, key_v, key_index, depth_sample, mask_sample,
               sil_row, sil_col, sil_flag,
        input  ready
    );
    modport sink (
        input  valid, kind, key_u, key_v, key_index, depth_sample, mask_sample,
               sil_row, sil_col, sil_flag,
        output ready
    );
endinterface

`default_nettype wire

### hdl/koes_out_if.sv
// result item channel
`default_nettype none

interface koes_out_if;
    logic                          valid;
    logic                          ready;
    logic [koes_pkg::INDEX_W-1:0]  out_index;
    logic [koes_pkg::CAT_W-1:0]    category;
    logic                          store_overflowed;

    modport source (
        output valid, out_index, category, store_overflowed,
        input  ready
    );
    modport sink (
        input  valid, out_index, category, store_overflowed,
        output ready
    );
endinterface

`default_nettype wire

### hdl/koes_cfg_if.sv
// configuration write channel
`default_nettype none

interface koes_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [koes_pkg::CFG_IDX_W-1:0]   index;
    logic [koes_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

### hdl/koes_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module koes_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/koes_ctrl.sv
// controller state machine of the keypoint splitter
`default_nettype none

module koes_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [koes_pkg::KIND_W-1:0] in_kind,
    output logic                             in_ready,
    input  wire koes_pkg::koes_stat_t        stat,
    output koes_pkg::koes_cmd_t              cmd
);

    koes_pkg::koes_state_t state_reg;
    koes_pkg::koes_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= koes_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            koes_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_kind)
                        koes_pkg::KIND_CLEAR: cmd.take_clear = 1'b1;
                        koes_pkg::KIND_LOAD:  cmd.take_load  = 1'b1;
                        koes_pkg::KIND_CLASSIFY:
                        begin
                            cmd.take_class = 1'b1;
                            state_next     = koes_pkg::ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            koes_pkg::ST_SCAN:
            begin
                if (!stat.scan_needed)
                begin
                    state_next = koes_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = koes_pkg::ST_DRAIN;
                    end
                end
            end
            koes_pkg::ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = koes_pkg::ST_FINISH;
                end
            end
            koes_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = koes_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = koes_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/koes_dp.sv
// datapath: configuration, silhouette store, distance pipeline, result register
`default_nettype none

module koes_dp #(
    parameter int MAX_POINTS = koes_pkg::MAX_POINTS_DEF,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire koes_pkg::koes_cmd_t                 cmd,
    output koes_pkg::koes_stat_t                     stat,
    // input item payload
    input  wire logic signed [koes_pkg::COORD_W-1:0] key_u,
    input  wire logic signed [koes_pkg::COORD_W-1:0] key_v,
    input  wire logic [koes_pkg::INDEX_W-1:0]        key_index,
    input  wire logic [koes_pkg::DEPTH_W-1:0]        depth_sample,
    input  wire logic [koes_pkg::MASK_W-1:0]         mask_sample,
    input  wire logic [koes_pkg::SIL_W-1:0]          sil_row,
    input  wire logic [koes_pkg::SIL_W-1:0]          sil_col,
    input  wire logic                                sil_flag,
    // configuration writes
    input  wire logic                                cfg_wr,
    input  wire logic [koes_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [koes_pkg::CFG_DATA_W-1:0]     cfg_data,
    // result
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [koes_pkg::INDEX_W-1:0]             out_index,
    output logic [koes_pkg::CAT_W-1:0]               category,
    output logic                                     store_overflowed
);

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
    localparam int DIFF_W = koes_pkg::COORD_W + 2;
    localparam int MAG_W  = koes_pkg::COORD_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 1;

    // configuration registers
    logic [koes_pkg::DIM_W-1:0]  width_reg;
    logic [koes_pkg::DIM_W-1:0]  height_reg;
    logic                        mask_present_reg;
    logic [koes_pkg::MASK_W-1:0] min_mask_reg;
    logic [koes_pkg::DIST_W-1:0] obj_dist_reg;
    logic [koes_pkg::DIST_W-1:0] env_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= koes_pkg::DIM_W'(640);
            height_reg       <= koes_pkg::DIM_W'(480);
            mask_present_reg <= 1'b0;
            min_mask_reg     <= '0;
            obj_dist_reg     <= '0;
            env_dist_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                koes_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[koes_pkg::DIM_W-1:0];
                koes_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[koes_pkg::DIM_W-1:0];
                koes_pkg::REG_MASK_PRESENT: mask_present_reg <= cfg_data[0];
                koes_pkg::REG_MIN_MASK:     min_mask_reg <= cfg_data[koes_pkg::MASK_W-1:0];
                koes_pkg::REG_OBJ_DIST:     obj_dist_reg <= cfg_data;
                koes_pkg::REG_ENV_DIST:     env_dist_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // store fill count and sticky overflow
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic          store_wr;

    assign store_wr = cmd.take_load && sil_flag && (count_reg < MAX_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.take_clear)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.take_load && sil_flag)
        begin
            if (count_reg < MAX_CNT)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // keypoint capture and the decisions that need no scan
    logic [koes_pkg::COORD_W-1:0] u_reg;
    logic [koes_pkg::COORD_W-1:0] v_reg;
    logic [koes_pkg::INDEX_W-1:0] idx_reg;
    logic [koes_pkg::DIST_W-1:0]  thr_reg;
    logic [koes_pkg::CAT_W-1:0]   pre_cat_reg;
    logic                         skip_reg;

    logic                         outside;
    logic                         use_mask;
    logic                         mask_ok;
    logic [koes_pkg::CAT_W-1:0]   pre_cat_next;
    logic                         skip_next;
    logic [koes_pkg::DIST_W-1:0]  thr_next;

    always_comb
    begin
        outside = key_u[koes_pkg::COORD_W-1] || key_v[koes_pkg::COORD_W-1]
               || ({1'b0, key_u} >= {width_reg, 4'b0000})
               || ({1'b0, key_v} >= {height_reg, 4'b0000});
        use_mask = mask_present_reg && (min_mask_reg != '0);
        mask_ok  = !use_mask || (mask_sample > min_mask_reg);
        thr_next = env_dist_reg;
        if (outside)
        begin
            pre_cat_next = koes_pkg::CAT_OUTSIDE;
            skip_next    = 1'b1;
        end
        else if (depth_sample != '0)
        begin
            pre_cat_next = mask_ok ? koes_pkg::CAT_OBJECT : koes_pkg::CAT_REJECT;
            skip_next    = !mask_ok;
            thr_next     = obj_dist_reg;
        end
        else
        begin
            pre_cat_next = koes_pkg::CAT_ENV;
            skip_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_class)
        begin
            u_reg       <= key_u;
            v_reg       <= key_v;
            idx_reg     <= key_index;
            thr_reg     <= thr_next;
            pre_cat_reg <= pre_cat_next;
            skip_reg    <= skip_next;
        end
    end

    // scan address counter
    logic [CW-1:0] addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cmd.take_class)
        begin
            addr_reg <= '0;
        end
        else if (cmd.scan_rd)
        begin
            addr_reg <= addr_reg + CW'(1);
        end
    end

    logic [koes_pkg::ENTRY_W-1:0] entry;

    koes_ram #(
        .WIDTH (koes_pkg::ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({sil_row, sil_col}),
        .rd_en   (cmd.scan_rd),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_data (entry)
    );

    // distance pipeline: read, square, compare
    logic               v1_reg;
    logic               v2_reg;
    logic               fail_reg;
    logic [SQ_W-1:0]    sq_row_reg;
    logic [SQ_W-1:0]    sq_col_reg;

    logic signed [DIFF_W-1:0] d_row;
    logic signed [DIFF_W-1:0] d_col;
    logic [MAG_W-1:0]         m_row;
    logic [MAG_W-1:0]         m_col;
    logic [SUM_W-1:0]         dist_sum;

    always_comb
    begin
        // silhouette pixel scaled to 1/16 pixel
        d_row = $signed({2'b00, entry[koes_pkg::ENTRY_W-1:koes_pkg::SIL_W], 4'b0000})
              - $signed({{2{v_reg[koes_pkg::COORD_W-1]}}, v_reg});
        d_col = $signed({2'b00, entry[koes_pkg::SIL_W-1:0], 4'b0000})
              - $signed({{2{u_reg[koes_pkg::COORD_W-1]}}, u_reg});
        m_row = d_row[DIFF_W-1] ? MAG_W'(-d_row) : MAG_W'(d_row);
        m_col = d_col[DIFF_W-1] ? MAG_W'(-d_col) : MAG_W'(d_col);
        dist_sum = {1'b0, sq_row_reg} + {1'b0, sq_col_reg};
    end

    always_ff @(posedge clk)
    begin
        sq_row_reg <= m_row * m_row;
        sq_col_reg <= m_col * m_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            fail_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_rd;
            v2_reg <= v1_reg;
            if (cmd.take_class)
            begin
                fail_reg <= 1'b0;
            end
            else if (v2_reg && (dist_sum < SUM_W'(thr_reg)))
            begin
                fail_reg <= 1'b1;
            end
        end
    end

    // result register
    logic                         out_valid_reg;
    logic [koes_pkg::INDEX_W-1:0] out_index_reg;
    logic [koes_pkg::CAT_W-1:0]   category_reg;
    logic                         ovf_out_reg;
    logic [koes_pkg::CAT_W-1:0]   final_cat;

    assign final_cat = (!skip_reg && fail_reg) ? koes_pkg::CAT_REJECT : pre_cat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_index_reg <= idx_reg;
            category_reg  <= final_cat;
            ovf_out_reg   <= ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_index        = out_index_reg;
    assign category         = category_reg;
    assign store_overflowed = ovf_out_reg;

    assign stat.scan_needed = !skip_reg && (count_reg != '0);
    assign stat.scan_last   = ((addr_reg + CW'(1)) == count_reg);
    assign stat.pipe_busy   = v1_reg || v2_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

### hdl/keypoint_object_environment_split.sv
// top level of the keypoint object/environment splitter
// clear and load items are taken in idle; a classify item holds the input off through scan,
// drain and finish, going from scan to finish if the store is empty or the keypoint is settled
// without a distance scan; scan reads one silhouette point per cycle and drain waits for the
// distance pipeline to empty; the result sits in an output register while the next item is taken
// rst_n at once resets state, config, fill count, overflow, out_valid; store, data are unset
`default_nettype none

module keypoint_object_environment_split #(
    parameter int MAX_POINTS = koes_pkg::MAX_POINTS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    koes_in_if.sink    item,
    koes_out_if.source result,
    koes_cfg_if.sink   cfg
);

    koes_pkg::koes_cmd_t  cmd;
    koes_pkg::koes_stat_t stat;

    assign cfg.ready = 1'b1;

    koes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_kind  (item.kind),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    koes_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .key_u            (item.key_u),
        .key_v            (item.key_v),
        .key_index        (item.key_index),
        .depth_sample     (item.depth_sample),
        .mask_sample      (item.mask_sample),
        .sil_row          (item.sil_row),
        .sil_col          (item.sil_col),
        .sil_flag         (item.sil_flag),
        .cfg_wr           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .out_index        (result.out_index),
        .category         (result.category),
        .store_overflowed (result.store_overflowed)
    );

endmodule

`default_nettype wire

### hdl/koes_checker.sv
// port-level checker of the keypoint splitter and its bind
`default_nettype none

`include "keypoint_object_environment_split_macros.svh"

module koes_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic [koes_pkg::KIND_W-1:0] in_kind,
    input wire logic                        out_valid,
    input wire logic                        out_ready
);

    // a pending result is never withdrawn
    `KOES_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    // a classify transfer blocks the input for at least the next cycle
    `KOES_ASSERT(a_class_busy, in_valid && in_ready && in_kind == koes_pkg::KIND_CLASSIFY |=> !in_ready, "input taken during classify")

    // a new result only shows up while the input is held off
    `KOES_ASSERT(a_out_rise, $rose(out_valid) |-> !$past(in_ready), "result without classify work")

    // no result is offered during reset
    `KOES_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !out_valid, "result valid in reset")

endmodule

bind keypoint_object_environment_split koes_checker u_koes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_kind   (item.kind),
    .out_valid (result.valid),
    .out_ready (result.ready)
);

`default_nettype wire
